// ===== rtl/sdt_pkg.sv =====
// Shared types and constants of the sorted descending table.
// Holds the transfer structs, operation and status codes and memory request type.
// No dependencies.
`default_nettype none

package sdt_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    op_e                operation;
    logic signed [31:0] value;
    logic [5:0]         position;
  } in_t;

  typedef struct packed {
    status_e            status;
    logic [6:0]         entry_count;
    logic [6:0]         removed_count;
    logic signed [31:0] read_value;
  } out_t;

  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
  } mem_req_t;

  typedef struct packed {
    logic             busy;
    logic             res_valid;
    logic [CNT_W-1:0] count;
  } ctl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/sorted_descending_table.sv =====
// Sorted descending table: top level with table memory, sequencer and output register.
// Depends on sdt_pkg, sdt_ram and sdt_ctrl.
//
// Keeps up to 64 signed 32-bit entries in descending order in a one-port-read,
// one-port-write RAM and takes one item at a time. An insert walks the RAM from the
// last entry down to its landing position and a delete walks every stored entry, one
// entry per cycle; a full insert, an empty delete, an out-of-range read or an unused
// code goes straight to the result. A finished result waits in the output register,
// so the next item is taken while it is still stalled. There is no clearing pass
// after reset.
`default_nettype none

module sorted_descending_table (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire sdt_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output sdt_pkg::out_t      out_data_o
);

  sdt_pkg::mem_req_t           mem;
  sdt_pkg::ctl_sts_t           sts;
  sdt_pkg::out_t               res;
  logic [sdt_pkg::DATA_W-1:0]  rd_data;
  logic                        res_take;
  logic                        out_valid_q, out_valid_d;
  sdt_pkg::out_t               out_data_q;

  sdt_ram #(
    .Depth(sdt_pkg::DEPTH),
    .Width(sdt_pkg::DATA_W)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (mem.wr_en),
    .wr_addr_i(mem.wr_addr),
    .wr_data_i(mem.wr_data),
    .rd_en_i  (mem.rd_en),
    .rd_addr_i(mem.rd_addr),
    .rd_data_o(rd_data)
  );

  sdt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_data_i (in_data_i),
    .res_take_i(res_take),
    .rd_data_i (rd_data),
    .mem_o     (mem),
    .sts_o     (sts),
    .res_o     (res)
  );

  assign in_stall_o = sts.busy;
  assign res_take   = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (sts.res_valid && res_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sts.res_valid && res_take) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.count <= sdt_pkg::CNT_W'(sdt_pkg::DEPTH))
    else $error("stored count beyond table depth");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("accepted transfer did not start the sequencer");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == sdt_pkg::ST_FULL)
      |-> (out_data_o.entry_count == 7'(sdt_pkg::DEPTH)))
    else $error("full status with table not full");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == sdt_pkg::ST_RANGE)
      |-> (out_data_o.read_value == '0 && out_data_o.removed_count == '0))
    else $error("out-of-range result carries data");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts.res_valid && res_take) |=> out_valid_o)
    else $error("result lost between sequencer and output register");

endmodule

`default_nettype wire

// ===== rtl/sdt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module sdt_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [Width-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sdt_ctrl.sv =====
// Sequencer of the sorted descending table: insert shift, delete compaction, read.
// Depends on sdt_pkg; drives the table memory through a mem_req_t.
`default_nettype none

module sdt_ctrl (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  input  wire sdt_pkg::in_t             in_data_i,
  input  wire logic                     res_take_i,
  input  wire logic [sdt_pkg::DATA_W-1:0] rd_data_i,
  output sdt_pkg::mem_req_t             mem_o,
  output sdt_pkg::ctl_sts_t             sts_o,
  output sdt_pkg::out_t                 res_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_INS  = 6'b000010,
    S_PUT  = 6'b000100,
    S_DEL  = 6'b001000,
    S_RD   = 6'b010000,
    S_EMIT = 6'b100000
  } state_e;

  state_e                        state_q, state_d;
  logic [sdt_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [sdt_pkg::IDX_W-1:0]     idx_q, idx_d;
  logic [sdt_pkg::CNT_W-1:0]     wr_q, wr_d;
  logic [sdt_pkg::CNT_W-1:0]     rem_q, rem_d;
  logic signed [31:0]            val_q, val_d;
  sdt_pkg::out_t                 res_q, res_d;
  logic                          greater;
  logic                          last;

  assign greater = $signed(rd_data_i) > val_q;
  assign last    = (sdt_pkg::CNT_W'(idx_q) + sdt_pkg::CNT_W'(1)) == cnt_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    wr_d    = wr_q;
    rem_d   = rem_q;
    val_d   = val_q;
    res_d   = res_q;
    mem_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          val_d             = in_data_i.value;
          res_d             = '0;
          res_d.status      = sdt_pkg::ST_OK;
          res_d.entry_count = 7'(cnt_q);
          unique case (in_data_i.operation)
            sdt_pkg::OP_INSERT: begin
              if (cnt_q >= sdt_pkg::CNT_W'(sdt_pkg::DEPTH)) begin
                res_d.status = sdt_pkg::ST_FULL;
                state_d      = S_EMIT;
              end else if (cnt_q == '0) begin
                cnt_d   = sdt_pkg::CNT_W'(1);
                state_d = S_PUT;
              end else begin
                mem_o.rd_en   = 1'b1;
                mem_o.rd_addr = sdt_pkg::IDX_W'(cnt_q - sdt_pkg::CNT_W'(1));
                idx_d         = sdt_pkg::IDX_W'(cnt_q - sdt_pkg::CNT_W'(1));
                cnt_d         = cnt_q + sdt_pkg::CNT_W'(1);
                state_d       = S_INS;
              end
            end
            sdt_pkg::OP_DELETE: begin
              if (cnt_q == '0) begin
                state_d = S_EMIT;
              end else begin
                mem_o.rd_en   = 1'b1;
                mem_o.rd_addr = '0;
                idx_d         = '0;
                wr_d          = '0;
                rem_d         = '0;
                state_d       = S_DEL;
              end
            end
            sdt_pkg::OP_READ: begin
              if ({26'd0, in_data_i.position} < 32'(cnt_q)) begin
                mem_o.rd_en   = 1'b1;
                mem_o.rd_addr = sdt_pkg::IDX_W'(in_data_i.position);
                state_d       = S_RD;
              end else begin
                res_d.status = sdt_pkg::ST_RANGE;
                state_d      = S_EMIT;
              end
            end
            default: begin
              state_d = S_EMIT;
            end
          endcase
        end
      end
      S_INS: begin
        mem_o.wr_en   = 1'b1;
        mem_o.wr_addr = idx_q + sdt_pkg::IDX_W'(1);
        if (greater) begin
          mem_o.wr_data     = val_q;
          res_d.entry_count = 7'(cnt_q);
          state_d           = S_EMIT;
        end else begin
          mem_o.wr_data = rd_data_i;
          if (idx_q == '0) begin
            state_d = S_PUT;
          end else begin
            mem_o.rd_en   = 1'b1;
            mem_o.rd_addr = idx_q - sdt_pkg::IDX_W'(1);
            idx_d         = idx_q - sdt_pkg::IDX_W'(1);
          end
        end
      end
      S_PUT: begin
        mem_o.wr_en       = 1'b1;
        mem_o.wr_addr     = '0;
        mem_o.wr_data     = val_q;
        res_d.entry_count = 7'(cnt_q);
        state_d           = S_EMIT;
      end
      S_DEL: begin
        if (rd_data_i == val_q) begin
          rem_d = rem_q + sdt_pkg::CNT_W'(1);
        end else begin
          mem_o.wr_en   = 1'b1;
          mem_o.wr_addr = sdt_pkg::IDX_W'(wr_q);
          mem_o.wr_data = rd_data_i;
          wr_d          = wr_q + sdt_pkg::CNT_W'(1);
        end
        if (last) begin
          cnt_d               = wr_d;
          res_d.entry_count   = 7'(wr_d);
          res_d.removed_count = 7'(rem_d);
          state_d             = S_EMIT;
        end else begin
          mem_o.rd_en   = 1'b1;
          mem_o.rd_addr = idx_q + sdt_pkg::IDX_W'(1);
          idx_d         = idx_q + sdt_pkg::IDX_W'(1);
        end
      end
      S_RD: begin
        res_d.read_value = rd_data_i;
        state_d          = S_EMIT;
      end
      S_EMIT: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    wr_q  <= wr_d;
    rem_q <= rem_d;
    val_q <= val_d;
    res_q <= res_d;
  end

  assign sts_o.busy      = (state_q != S_IDLE);
  assign sts_o.res_valid = (state_q == S_EMIT);
  assign sts_o.count     = cnt_q;
  assign res_o           = res_q;

endmodule

`default_nettype wire
